@@ rtl/core/pts_pkg.sv @@
// pts_pkg: shared types and constants for the periodic task scheduler
// no dependencies

package pts_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam logic [1:0] POL_RM  = 2'd0;
    localparam logic [1:0] POL_SJF = 2'd1;
    localparam logic [1:0] POL_MUF = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARD,
        ST_ARS,
        ST_ARW,
        ST_SRD,
        ST_SEL,
        ST_SMUL,
        ST_SCMP,
        ST_SRV,
        ST_SDN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] period;
        logic [23:0] exec;
        logic [15:0] deadline;
        logic [31:0] arrival;
        logic [15:0] consumed;
        logic        ready;
        logic [31:0] stamp;
    } entry_t;

endpackage

@@ rtl/core/periodic_task_scheduler_sim_unit.sv @@
// periodic_task_scheduler_sim_unit: top level of the periodic task scheduler
// depends on pts_pkg and pts_table

// A load transaction passes through the output state and back to idle, as does a tick
// with task_count 0. A tick runs as a sequencer over the task table memory. The arrival
// scan reads each active entry (states ARD, ARS) and ends in a write-back state (ARW);
// it runs again for every task found arriving. The selection scan passes each active
// entry through SRD, SEL and SCMP, and every ready entry after the first also through
// SMUL. It is followed by the served update (SRV) when a ready entry was found, and by
// SDN to advance the tick. The result is held in an output register until taken, so a
// receiver stall holds the block in ST_OUT. Valid bits make an entry that was never
// loaded read as zero. The ready flags live in flip-flops; the rest of each entry is
// held in the table memory.

module periodic_task_scheduler_sim_unit #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: task_index[2:0], task_period[18:3], exec_time_q8[42:19],
    // rel_deadline[58:43], zero fill up to 63
    input  logic [63:0] s_tdata,
    // tuser: req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: served_task[2:0], met_total[34:3], missed_total[66:35], zero fill
    output logic [71:0] m_tdata,
    // tuser: served_valid[0], job_done[1], deadline_ok[2]
    output logic [2:0]  m_tuser
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    pts_pkg::state_t state_reg, state_next;

    logic [1:0]   policy_reg;
    logic [3:0]   count_reg;
    logic [MAX_TASKS-1:0] ready_reg, ready_next;
    logic [MAX_TASKS-1:0] vld_reg, vld_next;
    logic [31:0]  tick_reg, tick_next;
    logic [31:0]  scnt_reg, scnt_next;
    logic [31:0]  met_reg, met_next;
    logic [31:0]  miss_reg, miss_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] best_reg, best_next;
    pts_pkg::entry_t be_reg, be_next;
    pts_pkg::entry_t ce_reg, ce_next;
    logic [39:0]  px_reg, px_next, py_reg, py_next;
    logic          ov_reg, ov_next;
    logic [2:0]    ou_reg, ou_next;
    logic [2:0]    ot_reg, ot_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    pts_pkg::entry_t wdata, rdata, rent;

    logic [2:0]   in_idx;
    logic [15:0]  in_per;
    logic [23:0]  in_exec;
    logic [15:0]  in_dl;

    assign in_idx  = s_tdata[2:0];
    assign in_per  = s_tdata[18:3];
    assign in_exec = s_tdata[42:19];
    assign in_dl   = s_tdata[58:43];

    pts_table #(.MAX_TASKS(MAX_TASKS), .IW(IW)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [CW-1:0] n_act;
    logic [IW-1:0] last_idx;
    always_comb
    begin
        if ({28'd0, count_reg} > MAX_TASKS)
        begin
            n_act = CW'(MAX_TASKS);
        end
        else
        begin
            n_act = CW'(count_reg);
        end
        last_idx = IW'(n_act - CW'(1));
    end

    // entry as read, with unwritten fields shown as reset values
    always_comb
    begin
        rent = rdata;
        if (!vld_reg[idx_reg])
        begin
            rent = '0;
        end
        rent.ready = ready_reg[idx_reg];
    end

    logic [16:0] need;
    logic [15:0] need_c, cons_inc;
    logic [41:0] lhs, rhs;
    logic        ce_cmp_lt, ce_cmp_eq;
    always_comb
    begin
        need = 17'((25'(be_reg.exec) + 25'd255) >> 8);
        need_c = (need > 17'd65535) ? 16'hffff : need[15:0];
        cons_inc = (be_reg.consumed != 16'hffff) ? be_reg.consumed + 16'd1 : 16'hffff;
        lhs = ({10'd0, tick_reg} + 42'd1) * 42'd256 + 42'(be_reg.exec);
        rhs = (42'(be_reg.arrival) + 42'(be_reg.deadline) + 42'(cons_inc)) * 42'd256;
        ce_cmp_lt = px_reg < py_reg;
        ce_cmp_eq = px_reg == py_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pts_pkg::ST_IDLE;
            policy_reg <= pts_pkg::POL_RM;
            count_reg  <= 4'd1;
            ready_reg  <= '0;
            vld_reg    <= '0;
            tick_reg   <= '0;
            scnt_reg   <= '0;
            met_reg    <= '0;
            miss_reg   <= '0;
            found_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            vld_reg   <= vld_next;
            tick_reg  <= tick_next;
            scnt_reg  <= scnt_next;
            met_reg   <= met_next;
            miss_reg  <= miss_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pts_pkg::CFG_POLICY: policy_reg <=
                        (cfg_wdata[1:0] == 2'd3) ? pts_pkg::POL_RM : cfg_wdata[1:0];
                    pts_pkg::CFG_COUNT: count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        be_reg   <= be_next;
        ce_reg   <= ce_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        ov_reg   <= ov_next;
        ou_reg   <= ou_next;
        ot_reg   <= ot_next;
    end

    assign s_tready = (state_reg == pts_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == pts_pkg::ST_OUT);
    assign m_tdata  = {5'd0, miss_reg, met_reg, ot_reg};
    assign m_tuser  = ou_reg;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        vld_next   = vld_reg;
        tick_next  = tick_reg;
        scnt_next  = scnt_reg;
        met_next   = met_reg;
        miss_next  = miss_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        be_next    = be_reg;
        ce_next    = ce_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        ov_next    = ov_reg;
        ou_next    = ou_reg;
        ot_next    = ot_reg;
        we    = 1'b0;
        waddr = idx_reg;
        wdata = be_reg;
        raddr = idx_reg;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                ou_next = 3'd0;
                ot_next = 3'd0;
                if (s_tvalid)
                begin
                    if (s_tuser == pts_pkg::REQ_LOAD)
                    begin
                        if ({29'd0, in_idx} < MAX_TASKS)
                        begin
                            we    = 1'b1;
                            waddr = IW'(in_idx);
                            wdata.period   = in_per;
                            wdata.exec     = in_exec;
                            wdata.deadline = in_dl;
                            wdata.arrival  = '0;
                            wdata.consumed = '0;
                            wdata.ready    = 1'b1;
                            wdata.stamp    = '0;
                            ready_next[IW'(in_idx)] = 1'b1;
                            vld_next[IW'(in_idx)]   = 1'b1;
                        end
                        state_next = pts_pkg::ST_OUT;
                    end
                    else if (n_act == '0)
                    begin
                        tick_next  = tick_reg + 32'd1;
                        state_next = pts_pkg::ST_OUT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = pts_pkg::ST_ARD;
                    end
                end
            end
            // arrival scan: read entry, compare
            pts_pkg::ST_ARD:
            begin
                state_next = pts_pkg::ST_ARS;
            end
            pts_pkg::ST_ARS:
            begin
                if (!rent.ready && rent.arrival <= tick_reg)
                begin
                    if (!found_reg || rent.arrival < be_reg.arrival ||
                        (rent.arrival == be_reg.arrival && rent.stamp < be_reg.stamp))
                    begin
                        found_next = 1'b1;
                        best_next  = idx_reg;
                        be_next    = rent;
                    end
                end
                if (idx_reg == last_idx)
                begin
                    state_next = pts_pkg::ST_ARW;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = pts_pkg::ST_ARD;
                end
            end
            pts_pkg::ST_ARW:
            begin
                idx_next = '0;
                if (found_reg)
                begin
                    we    = 1'b1;
                    waddr = best_reg;
                    wdata = be_reg;
                    wdata.ready = 1'b1;
                    wdata.stamp = scnt_reg + 32'd1;
                    scnt_next   = scnt_reg + 32'd1;
                    ready_next[best_reg] = 1'b1;
                    vld_next[best_reg]   = 1'b1;
                    found_next = 1'b0;
                    state_next = pts_pkg::ST_ARD;
                end
                else
                begin
                    state_next = pts_pkg::ST_SRD;
                end
            end
            // selection scan
            pts_pkg::ST_SRD:
            begin
                state_next = pts_pkg::ST_SEL;
            end
            pts_pkg::ST_SEL:
            begin
                ce_next = rent;
                if (!rent.ready)
                begin
                    state_next = pts_pkg::ST_SCMP;
                end
                else if (!found_reg)
                begin
                    found_next = 1'b1;
                    best_next  = idx_reg;
                    be_next    = rent;
                    state_next = pts_pkg::ST_SCMP;
                end
                else
                begin
                    state_next = pts_pkg::ST_SMUL;
                end
            end
            pts_pkg::ST_SMUL:
            begin
                case (policy_reg)
                    pts_pkg::POL_SJF:
                    begin
                        px_next = 40'(ce_reg.exec);
                        py_next = 40'(be_reg.exec);
                    end
                    pts_pkg::POL_MUF:
                    begin
                        px_next = 40'(be_reg.exec) * 40'(ce_reg.period);
                        py_next = 40'(ce_reg.exec) * 40'(be_reg.period);
                    end
                    default:
                    begin
                        px_next = 40'(ce_reg.period);
                        py_next = 40'(be_reg.period);
                    end
                endcase
                ce_next.ready = 1'b0;
                state_next = pts_pkg::ST_SCMP;
            end
            pts_pkg::ST_SCMP:
            begin
                // ce_reg.ready cleared marks a compare result pending
                if (ce_reg.ready == 1'b0 && ready_reg[idx_reg] && best_reg != idx_reg)
                begin
                    if (ce_cmp_lt || (ce_cmp_eq && ce_reg.stamp < be_reg.stamp))
                    begin
                        best_next = idx_reg;
                        be_next   = ce_reg;
                        be_next.ready = 1'b1;
                    end
                end
                if (idx_reg == last_idx)
                begin
                    state_next = found_reg ? pts_pkg::ST_SRV : pts_pkg::ST_SDN;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = pts_pkg::ST_SRD;
                end
            end
            pts_pkg::ST_SRV:
            begin
                we    = 1'b1;
                waddr = best_reg;
                wdata = be_reg;
                vld_next[best_reg] = 1'b1;
                ou_next = 3'b001;
                ot_next = 3'(best_reg);
                if (cons_inc >= need_c)
                begin
                    ou_next[1] = 1'b1;
                    if (lhs <= rhs)
                    begin
                        ou_next[2] = 1'b1;
                        if (met_reg != 32'hffffffff)
                        begin
                            met_next = met_reg + 32'd1;
                        end
                    end
                    else if (miss_reg != 32'hffffffff)
                    begin
                        miss_next = miss_reg + 32'd1;
                    end
                    wdata.arrival  = be_reg.arrival + 32'(be_reg.period);
                    wdata.consumed = '0;
                    wdata.ready    = 1'b0;
                    wdata.stamp    = scnt_reg + 32'd1;
                    scnt_next      = scnt_reg + 32'd1;
                    ready_next[best_reg] = 1'b0;
                end
                else
                begin
                    wdata.consumed = cons_inc;
                end
                state_next = pts_pkg::ST_SDN;
            end
            pts_pkg::ST_SDN:
            begin
                tick_next  = tick_reg + 32'd1;
                state_next = pts_pkg::ST_OUT;
            end
            pts_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/pts_table.sv @@
// pts_table: task table memory, one write port and one registered read port
// depends on pts_pkg

module pts_table #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
    parameter int IW = $clog2(MAX_TASKS)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IW-1:0]        waddr,
    input  pts_pkg::entry_t      wdata,
    input  logic [IW-1:0]        raddr,
    output pts_pkg::entry_t      rdata
);

    pts_pkg::entry_t mem [MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
